// ===== design/cpu816_pkg.sv =====
// cpu816_pkg: shared types, opcode codes and flag positions for the 65816 subset
// execute block. Used by cpu816_exec, the top level and the checker.
// Depends on nothing.
`timescale 1ns / 1ps

package cpu816_pkg;

  // supported opcodes
  localparam logic [7:0] OP_CLC     = 8'h18;
  localparam logic [7:0] OP_XCE     = 8'hFB;
  localparam logic [7:0] OP_REP     = 8'hC2;
  localparam logic [7:0] OP_SEP     = 8'hE2;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_STA_ABY = 8'h99;
  localparam logic [7:0] OP_STA_ABX = 8'h9D;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_CPX_IMM = 8'hE0;
  localparam logic [7:0] OP_BNE     = 8'hD0;
  localparam logic [7:0] OP_TXS     = 8'h9A;

  // status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_X = 4;
  localparam int unsigned FLAG_M = 5;
  localparam int unsigned FLAG_N = 7;

  // store byte counts
  localparam logic [1:0] STORE_NONE = 2'd0;
  localparam logic [1:0] STORE_BYTE = 2'd1;
  localparam logic [1:0] STORE_WORD = 2'd2;

  localparam logic [15:0] PC_RESET = 16'h8000;

  // beat widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 128;

  // one instruction beat
  typedef struct packed {
    logic [7:0] operand_high;
    logic [7:0] operand_low;
    logic [7:0] opcode;
  } instr_t;

  // architectural registers
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  status;
    logic [15:0] sp;
    logic [15:0] idx_y;
    logic [15:0] idx_x;
    logic [15:0] acc;
  } arch_t;

  // per-instruction side results
  typedef struct packed {
    logic        unknown;
    logic [2:0]  cycles;
    logic [15:0] store_data;
    logic [15:0] store_addr;
    logic [1:0]  store_count;
  } exec_info_t;

  // {n, z} for a value at 8 or 16 bits
  function automatic logic [1:0] nz_flags(input logic [15:0] value, input logic narrow);
    logic n;
    logic z;
    if (narrow) begin
      n = value[7];
      z = (value[7:0] == 8'h00);
    end else begin
      n = value[15];
      z = (value == 16'h0000);
    end
    return {n, z};
  endfunction

endpackage

// ===== design/cpu816_exec.sv =====
// cpu816_exec: combinational execute of one instruction against the current
// register set. Produces the next register set and the store / cycle info.
// Depends on cpu816_pkg.
`timescale 1ns / 1ps

module cpu816_exec (
  input  cpu816_pkg::instr_t     instr_i,
  input  cpu816_pkg::arch_t      state_i,
  output cpu816_pkg::arch_t      state_o,
  output cpu816_pkg::exec_info_t info_o
);

  always_comb begin
    logic        m8;
    logic        x8;
    logic [15:0] word;
    logic [15:0] len;
    logic [15:0] imm;
    logic [15:0] xv;
    logic [15:0] diff;
    logic [15:0] x_inc;
    logic [1:0]  nz;
    cpu816_pkg::arch_t      st;
    cpu816_pkg::exec_info_t inf;

    m8    = state_i.status[cpu816_pkg::FLAG_M];
    x8    = state_i.status[cpu816_pkg::FLAG_X];
    word  = {instr_i.operand_high, instr_i.operand_low};
    imm   = x8 ? {8'h00, instr_i.operand_low} : word;
    xv    = x8 ? {8'h00, state_i.idx_x[7:0]} : state_i.idx_x;
    diff  = xv - imm;
    x_inc = state_i.idx_x + 16'd1;
    if (x8) begin
      x_inc = {8'h00, x_inc[7:0]};
    end
    nz    = 2'b00;
    st    = state_i;
    len   = 16'd1;
    inf   = '0;
    inf.cycles = 3'd2;

    unique case (instr_i.opcode)
      cpu816_pkg::OP_CLC: begin
        st.status[cpu816_pkg::FLAG_C] = 1'b0;
      end
      cpu816_pkg::OP_XCE: begin
        st = state_i;
      end
      cpu816_pkg::OP_REP: begin
        st.status  = state_i.status & ~instr_i.operand_low;
        len        = 16'd2;
        inf.cycles = 3'd3;
      end
      cpu816_pkg::OP_SEP: begin
        st.status  = state_i.status | instr_i.operand_low;
        if (st.status[cpu816_pkg::FLAG_X]) begin
          st.idx_x = {8'h00, state_i.idx_x[7:0]};
          st.idx_y = {8'h00, state_i.idx_y[7:0]};
        end
        len        = 16'd2;
        inf.cycles = 3'd3;
      end
      cpu816_pkg::OP_LDA_IMM: begin
        if (m8) begin
          st.acc     = {state_i.acc[15:8], instr_i.operand_low};
          len        = 16'd2;
          inf.cycles = 3'd2;
        end else begin
          st.acc     = word;
          len        = 16'd3;
          inf.cycles = 3'd3;
        end
        nz = cpu816_pkg::nz_flags(st.acc, m8);
        st.status[cpu816_pkg::FLAG_N] = nz[1];
        st.status[cpu816_pkg::FLAG_Z] = nz[0];
      end
      cpu816_pkg::OP_LDX_IMM, cpu816_pkg::OP_LDY_IMM: begin
        if (instr_i.opcode == cpu816_pkg::OP_LDX_IMM) begin
          st.idx_x = imm;
        end else begin
          st.idx_y = imm;
        end
        len        = x8 ? 16'd2 : 16'd3;
        inf.cycles = x8 ? 3'd2 : 3'd3;
        nz = cpu816_pkg::nz_flags(imm, x8);
        st.status[cpu816_pkg::FLAG_N] = nz[1];
        st.status[cpu816_pkg::FLAG_Z] = nz[0];
      end
      cpu816_pkg::OP_STA_ABS, cpu816_pkg::OP_STA_ABY, cpu816_pkg::OP_STA_ABX: begin
        // base plus optional index, wrapping in 16 bits
        inf.store_addr = word;
        if (instr_i.opcode == cpu816_pkg::OP_STA_ABY) begin
          inf.store_addr = word + state_i.idx_y;
        end else if (instr_i.opcode == cpu816_pkg::OP_STA_ABX) begin
          inf.store_addr = word + state_i.idx_x;
        end
        inf.cycles = (instr_i.opcode == cpu816_pkg::OP_STA_ABS) ? 3'd4 : 3'd5;
        if (m8) begin
          inf.store_count = cpu816_pkg::STORE_BYTE;
          inf.store_data  = {8'h00, state_i.acc[7:0]};
        end else begin
          inf.store_count = cpu816_pkg::STORE_WORD;
          inf.store_data  = state_i.acc;
          inf.cycles      = inf.cycles + 3'd1;
        end
        len = 16'd3;
      end
      cpu816_pkg::OP_INX: begin
        st.idx_x = x_inc;
        nz = cpu816_pkg::nz_flags(x_inc, x8);
        st.status[cpu816_pkg::FLAG_N] = nz[1];
        st.status[cpu816_pkg::FLAG_Z] = nz[0];
      end
      cpu816_pkg::OP_CPX_IMM: begin
        len        = x8 ? 16'd2 : 16'd3;
        inf.cycles = x8 ? 3'd2 : 3'd3;
        st.status[cpu816_pkg::FLAG_N] = x8 ? diff[7] : diff[15];
        st.status[cpu816_pkg::FLAG_Z] = (xv == imm);
        st.status[cpu816_pkg::FLAG_C] = (xv >= imm);
      end
      cpu816_pkg::OP_BNE: begin
        // taken branch: sign-extended offset from the next instruction
        len = 16'd2;
        if (!state_i.status[cpu816_pkg::FLAG_Z]) begin
          len        = 16'd2 + {{8{instr_i.operand_low[7]}}, instr_i.operand_low};
          inf.cycles = 3'd3;
        end
      end
      cpu816_pkg::OP_TXS: begin
        st.sp = state_i.idx_x;
      end
      default: begin
        inf.unknown = 1'b1;
        len         = 16'd0;
      end
    endcase

    st.pc   = state_i.pc + len;
    state_o = st;
    info_o  = inf;
  end

endmodule

// ===== design/cpu_65816_subset_execute_top.sv =====
// cpu_65816_subset_execute_top: 65816 subset execute block with input and
// result registers around one combinational execute stage.
// Depends on cpu816_pkg and cpu816_exec.
//
//   channel   direction  tdata                                   tuser
//   s_axis    in         24b: opcode, operand_low, operand_high  -
//   m_axis    out        128b: register set, store, cycle count  unknown_opcode
//
// One instruction retires per clock while m_axis is not stalled: an accepted
// beat sits in the input register, executes against A/X/Y/SP/P/PC from there
// and lands in the result register. The register set updates in the cycle the
// instruction moves into the result register. A stall on m_axis holds the
// result; s_axis keeps taking a beat while the input register is empty or
// moving on. Reset clears A, X, Y, SP and P and sets PC to 0x8000.
`timescale 1ns / 1ps

module cpu_65816_subset_execute_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] opcode, [15:8] operand_low, [23:16] operand_high
  input  logic [cpu816_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] acc_value, [31:16] index_x_value, [47:32] index_y_value,
  // [63:48] stack_value, [71:64] status_value, [87:72] counter_value,
  // [89:88] store_count, [105:90] store_address, [121:106] store_data,
  // [124:122] cycle_count, [127:125] zero
  output logic [cpu816_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] unknown_opcode
  output logic                             m_axis_tuser
);

  logic                   in_valid_q, in_valid_d;
  cpu816_pkg::instr_t     instr_q;
  logic                   out_valid_q, out_valid_d;
  cpu816_pkg::arch_t      arch_q, arch_d;
  cpu816_pkg::arch_t      res_state_q;
  cpu816_pkg::exec_info_t res_info_q;
  cpu816_pkg::exec_info_t info_d;
  logic                   s_beat;
  logic                   advance;

  // handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_beat) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // execute stage
  cpu816_exec u_exec (
    .instr_i (instr_q),
    .state_i (arch_q),
    .state_o (arch_d),
    .info_o  (info_d)
  );

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      arch_q      <= '{pc: cpu816_pkg::PC_RESET, default: '0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        arch_q <= arch_d;
      end
    end
  end

  // input and result payload
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      instr_q <= cpu816_pkg::instr_t'(s_axis_tdata);
    end
    if (advance) begin
      res_state_q <= arch_d;
      res_info_q  <= info_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_info_q.unknown;
  assign m_axis_tdata  = {3'b000,
                          res_info_q.cycles,
                          res_info_q.store_data,
                          res_info_q.store_addr,
                          res_info_q.store_count,
                          res_state_q.pc,
                          res_state_q.status,
                          res_state_q.sp,
                          res_state_q.idx_y,
                          res_state_q.idx_x,
                          res_state_q.acc};

endmodule

// ===== design/cpu816_checker.sv =====
// cpu816_checker: port-level assertions for the execute block, bound to the
// top level. Depends on cpu816_pkg and cpu_65816_subset_execute_top.
`timescale 1ns / 1ps

module cpu816_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  logic [1:0]  store_count;
  logic [15:0] store_data;
  logic [15:0] store_addr;
  logic [2:0]  cycles;
  logic [7:0]  status;

  assign status      = m_axis_tdata[71:64];
  assign store_count = m_axis_tdata[89:88];
  assign store_addr  = m_axis_tdata[105:90];
  assign store_data  = m_axis_tdata[121:106];
  assign cycles      = m_axis_tdata[124:122];

  // unknown opcode: no store, cycle count field left at its default
  a_unknown_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      store_count == cpu816_pkg::STORE_NONE && cycles == 3'd2)
    else $error("unknown opcode reported with store or odd cycle count");

  // no store carries zero address and data
  a_no_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && store_count == cpu816_pkg::STORE_NONE |->
      store_addr == 16'h0000 && store_data == 16'h0000)
    else $error("store fields nonzero without a store");

  // byte store matches 8-bit accumulator mode
  a_byte_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && store_count == cpu816_pkg::STORE_BYTE |->
      status[cpu816_pkg::FLAG_M] && store_data[15:8] == 8'h00 && cycles >= 3'd4)
    else $error("byte store inconsistent with M flag or data");

  // word store matches 16-bit accumulator mode
  a_word_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && store_count == cpu816_pkg::STORE_WORD |->
      !status[cpu816_pkg::FLAG_M] && cycles >= 3'd5)
    else $error("word store inconsistent with M flag or cycle count");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

endmodule

bind cpu_65816_subset_execute_top cpu816_checker u_cpu816_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
